@@ hw/rtl/lasm_pkg.sv @@
// lasm_pkg: shared types, sizes and character codes of the line assembler
// depends on nothing; used by lasm_ctrl, lasm_out and the top level

package lasm_pkg;

  localparam int unsigned LINE_BYTES  = 64;
  localparam int unsigned QUEUE_LINES = 8;

  localparam int unsigned CAP        = LINE_BYTES - 1;
  localparam int unsigned POS_W      = $clog2(LINE_BYTES);
  localparam int unsigned BUF_AW     = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned SLOT_W     = (QUEUE_LINES > 1) ? $clog2(QUEUE_LINES) : 1;
  localparam int unsigned CNT_W      = $clog2(QUEUE_LINES + 1);
  localparam int unsigned LINE_DEPTH = QUEUE_LINES * CAP;
  localparam int unsigned LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned STAT_W      = 32;
  localparam int unsigned QUEUED_W    = 4;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 144;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_ERROR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESULT,
    S_COPY,
    S_SCAN,
    S_SCAN_W,
    S_EMIT,
    S_EMIT_W
  } state_e;

  typedef struct packed {
    logic              avail;
    logic              valid;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [QUEUED_W-1:0] queued;
    logic [STAT_W-1:0]   received;
    logic [STAT_W-1:0]   dropped;
    logic [STAT_W-1:0]   overflowed;
    logic [STAT_W-1:0]   errors;
  } stat_t;

  function automatic logic [LINE_AW-1:0] line_addr(logic [SLOT_W-1:0] slot,
                                                   logic [BUF_AW-1:0] idx);
    return LINE_AW'(slot) * LINE_AW'(CAP) + LINE_AW'(idx);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(logic [SLOT_W-1:0] slot);
    return (slot == SLOT_W'(QUEUE_LINES - 1)) ? '0 : slot + SLOT_W'(1);
  endfunction

endpackage

@@ hw/rtl/lasm_ram.sv @@
// lasm_ram: simple dual-port synchronous ram, one write and one read port
// read data registered; no dependencies

module lasm_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lasm_ctrl.sv @@
// lasm_ctrl: sequencer, build and line memories, ring pointers and counters
// depends on lasm_pkg and lasm_ram

module lasm_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lasm_pkg::OP_W-1:0]           in_op_i,
  input  logic [lasm_pkg::CHAR_W-1:0]         in_byte_i,
  input  logic [lasm_pkg::SIZE_W-1:0]         in_size_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output lasm_pkg::res_t                      res_o,
  output lasm_pkg::stat_t                     stat_o
);

  localparam int unsigned POS_W  = lasm_pkg::POS_W;
  localparam int unsigned SLOT_W = lasm_pkg::SLOT_W;
  localparam int unsigned CNT_W  = lasm_pkg::CNT_W;
  localparam int unsigned STAT_W = lasm_pkg::STAT_W;
  localparam int unsigned BUF_AW = lasm_pkg::BUF_AW;

  lasm_pkg::state_e state_q, state_d;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic              flag_q, flag_d;
  logic [SLOT_W-1:0] wslot_q, wslot_d, rslot_q, rslot_d, rs_q, rs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [STAT_W-1:0] acc_q, acc_d, drop_q, drop_d, ovf_q, ovf_d, err_q, err_d;
  logic [POS_W-1:0]  lim_q, lim_d, sidx_q, sidx_d, n_q, n_d, eidx_q, eidx_d;
  logic [POS_W-1:0]  cp_q, cp_d, cpa_q, cpa_d;
  logic              cpv_q, cpv_d;
  logic              avail_q, avail_d;

  logic [POS_W-1:0]  len_q [lasm_pkg::QUEUE_LINES];
  logic              len_we;

  logic                            accept, is_nl, is_cr, can_commit, ring_full, rd_ok;
  logic [POS_W-1:0]                cur_len, lim_calc;
  logic [lasm_pkg::SIZE_W-1:0]     size_m1;
  logic                            sidx_end, eidx_end, copy_done;

  logic                            b_we, b_re;
  logic [BUF_AW-1:0]               b_waddr, b_raddr;
  logic [lasm_pkg::CHAR_W-1:0]     b_rdata;
  logic                            l_we, l_re;
  logic [lasm_pkg::LINE_AW-1:0]    l_waddr, l_raddr;
  logic [lasm_pkg::CHAR_W-1:0]     l_rdata;

  lasm_ram #(
    .DEPTH (lasm_pkg::CAP),
    .WIDTH (lasm_pkg::CHAR_W)
  ) u_build_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (in_byte_i),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  lasm_ram #(
    .DEPTH (lasm_pkg::LINE_DEPTH),
    .WIDTH (lasm_pkg::CHAR_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (b_rdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  assign in_ready_o = (state_q == lasm_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_nl      = (in_byte_i == lasm_pkg::CH_NL);
  assign is_cr      = (in_byte_i == lasm_pkg::CH_CR);
  assign can_commit = !flag_q && (pos_q != '0);
  assign ring_full  = (cnt_q == CNT_W'(lasm_pkg::QUEUE_LINES));
  assign rd_ok      = (in_size_i != '0) && (cnt_q != '0);
  assign cur_len    = len_q[rslot_q];
  assign size_m1    = in_size_i - lasm_pkg::SIZE_W'(1);
  assign lim_calc   = (lasm_pkg::SIZE_W'(cur_len) <= size_m1) ? cur_len
                                                              : size_m1[POS_W-1:0];
  assign sidx_end   = ((sidx_q + POS_W'(1)) == lim_q);
  assign eidx_end   = ((eidx_q + POS_W'(1)) == n_q);
  assign copy_done  = (cp_q == pos_q) && !cpv_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lasm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            lasm_pkg::OP_BYTE: begin
              state_d = (is_nl && can_commit && !ring_full) ? lasm_pkg::S_COPY
                                                            : lasm_pkg::S_RESULT;
            end
            lasm_pkg::OP_READ: begin
              state_d = (rd_ok && (lim_calc != '0)) ? lasm_pkg::S_SCAN
                                                    : lasm_pkg::S_RESULT;
            end
            default: state_d = lasm_pkg::S_RESULT;
          endcase
        end
      end
      lasm_pkg::S_RESULT: begin
        if (res_ready_i) state_d = lasm_pkg::S_IDLE;
      end
      lasm_pkg::S_COPY: begin
        if (copy_done) state_d = lasm_pkg::S_RESULT;
      end
      lasm_pkg::S_SCAN: state_d = lasm_pkg::S_SCAN_W;
      lasm_pkg::S_SCAN_W: begin
        if (l_rdata == lasm_pkg::CH_NUL) begin
          state_d = (sidx_q == '0) ? lasm_pkg::S_RESULT : lasm_pkg::S_EMIT;
        end else if (sidx_end) begin
          state_d = lasm_pkg::S_EMIT;
        end else begin
          state_d = lasm_pkg::S_SCAN;
        end
      end
      lasm_pkg::S_EMIT: state_d = lasm_pkg::S_EMIT_W;
      lasm_pkg::S_EMIT_W: begin
        if (res_ready_i) state_d = eidx_end ? lasm_pkg::S_IDLE : lasm_pkg::S_EMIT;
      end
      default: state_d = lasm_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pos_d   = pos_q;
    flag_d  = flag_q;
    wslot_d = wslot_q;
    rslot_d = rslot_q;
    rs_d    = rs_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    drop_d  = drop_q;
    ovf_d   = ovf_q;
    err_d   = err_q;
    lim_d   = lim_q;
    sidx_d  = sidx_q;
    n_d     = n_q;
    eidx_d  = eidx_q;
    cp_d    = cp_q;
    cpa_d   = cpa_q;
    cpv_d   = cpv_q;
    avail_d = avail_q;
    len_we  = 1'b0;
    b_we    = 1'b0;
    b_waddr = pos_q[BUF_AW-1:0];
    b_re    = 1'b0;
    b_raddr = cp_q[BUF_AW-1:0];
    l_we    = 1'b0;
    l_waddr = lasm_pkg::line_addr(wslot_q, cpa_q[BUF_AW-1:0]);
    l_re    = 1'b0;
    l_raddr = lasm_pkg::line_addr(rs_q, sidx_q[BUF_AW-1:0]);
    res_valid_o = 1'b0;
    res_o       = '{avail: avail_q, valid: 1'b0, ch: lasm_pkg::CH_NUL, last: 1'b1};

    unique case (state_q)
      lasm_pkg::S_IDLE: begin
        if (accept) begin
          avail_d = 1'b0;
          unique case (in_op_i)
            lasm_pkg::OP_BYTE: begin
              if (is_nl) begin
                if (can_commit && !ring_full) begin
                  cp_d  = '0;
                  cpv_d = 1'b0;
                end else begin
                  pos_d  = '0;
                  flag_d = 1'b0;
                  if (can_commit) drop_d = drop_q + STAT_W'(1);
                  else if (flag_q) ovf_d = ovf_q + STAT_W'(1);
                end
              end else if (!is_cr && !flag_q) begin
                if (pos_q < POS_W'(lasm_pkg::CAP)) begin
                  b_we  = 1'b1;
                  pos_d = pos_q + POS_W'(1);
                end else begin
                  flag_d = 1'b1;
                end
              end
            end
            lasm_pkg::OP_ERROR: begin
              pos_d  = '0;
              flag_d = 1'b0;
              err_d  = err_q + STAT_W'(1);
            end
            lasm_pkg::OP_READ: begin
              if (rd_ok) begin
                avail_d = 1'b1;
                rs_d    = rslot_q;
                lim_d   = lim_calc;
                sidx_d  = '0;
                rslot_d = lasm_pkg::slot_inc(rslot_q);
                cnt_d   = cnt_q - CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      lasm_pkg::S_RESULT: begin
        res_valid_o = 1'b1;
      end
      lasm_pkg::S_COPY: begin
        l_we = cpv_q;
        if (cp_q != pos_q) begin
          b_re  = 1'b1;
          cpv_d = 1'b1;
          cpa_d = cp_q;
          cp_d  = cp_q + POS_W'(1);
        end else begin
          cpv_d = 1'b0;
          if (!cpv_q) begin
            len_we  = 1'b1;
            acc_d   = acc_q + STAT_W'(1);
            cnt_d   = cnt_q + CNT_W'(1);
            wslot_d = lasm_pkg::slot_inc(wslot_q);
            pos_d   = '0;
            flag_d  = 1'b0;
          end
        end
      end
      lasm_pkg::S_SCAN: begin
        l_re = 1'b1;
      end
      lasm_pkg::S_SCAN_W: begin
        eidx_d = '0;
        if (l_rdata == lasm_pkg::CH_NUL) begin
          n_d = sidx_q;
        end else if (sidx_end) begin
          n_d = lim_q;
        end else begin
          sidx_d = sidx_q + POS_W'(1);
        end
      end
      lasm_pkg::S_EMIT: begin
        l_re    = 1'b1;
        l_raddr = lasm_pkg::line_addr(rs_q, eidx_q[BUF_AW-1:0]);
      end
      lasm_pkg::S_EMIT_W: begin
        res_valid_o = 1'b1;
        res_o       = '{avail: 1'b1, valid: 1'b1, ch: l_rdata, last: eidx_end};
        if (res_ready_i) eidx_d = eidx_q + POS_W'(1);
      end
      default: ;
    endcase
  end

  assign stat_o = '{
    queued:     lasm_pkg::QUEUED_W'(cnt_q),
    received:   acc_q,
    dropped:    drop_q,
    overflowed: ovf_q,
    errors:     err_q
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lasm_pkg::S_IDLE;
      pos_q   <= '0;
      flag_q  <= 1'b0;
      wslot_q <= '0;
      rslot_q <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      drop_q  <= '0;
      ovf_q   <= '0;
      err_q   <= '0;
      cpv_q   <= 1'b0;
      avail_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      flag_q  <= flag_d;
      wslot_q <= wslot_d;
      rslot_q <= rslot_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      drop_q  <= drop_d;
      ovf_q   <= ovf_d;
      err_q   <= err_d;
      cpv_q   <= cpv_d;
      avail_q <= avail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q   <= rs_d;
    lim_q  <= lim_d;
    sidx_q <= sidx_d;
    n_q    <= n_d;
    eidx_q <= eidx_d;
    cp_q   <= cp_d;
    cpa_q  <= cpa_d;
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_q[wslot_q] <= pos_q;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(lasm_pkg::QUEUE_LINES))
    else $error("line count beyond ring depth");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(lasm_pkg::CAP))
    else $error("build position beyond capacity");

  a_flag_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flag_q |-> (pos_q == POS_W'(lasm_pkg::CAP)))
    else $error("overflow flag set on a line that is not full");

  a_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wslot_q == rslot_q) |-> ((cnt_q == '0) || (cnt_q == CNT_W'(lasm_pkg::QUEUE_LINES))))
    else $error("ring pointers disagree with line count");

  a_copy_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lasm_pkg::S_COPY) |-> (!res_valid_o && !in_ready_o))
    else $error("result or input taken during line copy");

endmodule

@@ hw/rtl/lasm_out.sv @@
// lasm_out: output register stage, packs result and status into the stream word
// depends on lasm_pkg

module lasm_out (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  lasm_pkg::res_t                       res_i,
  input  lasm_pkg::stat_t                      stat_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [lasm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic [lasm_pkg::OUT_TUSER_W-1:0]     m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);

  localparam int unsigned PAY_W = lasm_pkg::CHAR_W + lasm_pkg::QUEUED_W
                                  + 4 * lasm_pkg::STAT_W;

  logic           full_q, full_d;
  lasm_pkg::res_t  res_q;
  lasm_pkg::stat_t stat_q;
  logic           load;

  assign ready_o = !full_q || m_axis_tready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    full_d = full_q;
    if (load) full_d = 1'b1;
    else if (m_axis_tready_i) full_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= res_i;
      stat_q <= stat_i;
    end
  end

  assign m_axis_tvalid_o = full_q;
  assign m_axis_tdata_o  = lasm_pkg::OUT_TDATA_W'({stat_q.errors, stat_q.overflowed,
                                                   stat_q.dropped, stat_q.received,
                                                   stat_q.queued, res_q.ch});
  assign m_axis_tuser_o  = {res_q.valid, res_q.avail};
  assign m_axis_tlast_o  = res_q.last;

  a_pay_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PAY_W <= lasm_pkg::OUT_TDATA_W) || !full_q)
    else $error("payload wider than stream word");

endmodule

@@ hw/rtl/line_assembler_with_line_queue.sv @@
// line_assembler_with_line_queue: top level of the line assembler
// depends on lasm_pkg, lasm_ctrl, lasm_out
//
// channel  dir  handshake               payload
// s_axis   in   tvalid_i / tready_o     tuser: op; tdata: rx_byte, dest_size
// m_axis   out  tvalid_o / tready_i     tuser: line_popped, char_valid;
//                                       tdata: char_out, queued_lines, counters;
//                                       tlast: last word of an input word
//
// one input word at a time; a byte or error word goes from idle to the result state
// a committing newline first copies the line from the build ram into the line ram
// a read scans the stored line byte by byte, then streams each char as its own word
// reset clears pointers, counters and flags; ram contents are not cleared
// a stalled output holds its word in the output register; the sequencer waits

module line_assembler_with_line_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [lasm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,  // rx_byte, dest_size
  input  logic [lasm_pkg::OP_W-1:0]           s_axis_tuser_i,  // op
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // char_out, queued_lines, lines_taken, lines_lost, lines_overflowed,
  // hw_errors, zero pad
  output logic [lasm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic [lasm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,  // line_popped, char_valid
  output logic                                m_axis_tlast_o   // last
);

  logic            res_valid, res_ready;
  lasm_pkg::res_t  res;
  lasm_pkg::stat_t stat;

  lasm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_byte_i   (s_axis_tdata_i[lasm_pkg::CHAR_W-1:0]),
    .in_size_i   (s_axis_tdata_i[lasm_pkg::CHAR_W +: lasm_pkg::SIZE_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .stat_o      (stat)
  );

  lasm_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (res_valid),
    .ready_o         (res_ready),
    .res_i           (res),
    .stat_i          (stat),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for line_assembler_with_line_queue
// depends on lasm_pkg and the rtl top level; drives bytes, error events and
// line reads, predicts every output word and compares it field by field
`timescale 1ns / 100ps

module tb;

  localparam int unsigned OP_W        = lasm_pkg::OP_W;
  localparam int unsigned CHAR_W      = lasm_pkg::CHAR_W;
  localparam int unsigned SIZE_W      = lasm_pkg::SIZE_W;
  localparam int unsigned STAT_W      = lasm_pkg::STAT_W;
  localparam int unsigned QUEUED_W    = lasm_pkg::QUEUED_W;
  localparam int unsigned POS_W       = lasm_pkg::POS_W;
  localparam int unsigned SLOT_W      = lasm_pkg::SLOT_W;
  localparam int unsigned CNT_W       = lasm_pkg::CNT_W;
  localparam int unsigned CAP         = lasm_pkg::CAP;
  localparam int unsigned QUEUE_LINES = lasm_pkg::QUEUE_LINES;
  localparam int unsigned IN_TDATA_W  = lasm_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = lasm_pkg::OUT_TDATA_W;
  localparam int unsigned OUT_TUSER_W = lasm_pkg::OUT_TUSER_W;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 5000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int END_CYCLES   = 300;
  localparam int RANDOM_WORDS = 210;
  localparam int PRINT_LIMIT  = 40;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] rx;
    logic [SIZE_W-1:0] size;
    int                gap;
  } serial_word_t;

  typedef struct packed {
    lasm_pkg::res_t  res;
    lasm_pkg::stat_t st;
  } line_word_t;

  logic clk_i;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = '0;
  logic m_ready = 1'b0;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  line_assembler_with_line_queue u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),  // rx_byte, dest_size
    .s_axis_tuser_i  (s_tuser),  // op
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  serial_word_t pending_words[$];
  line_word_t   expected_words[$];
  serial_word_t next_word;
  line_word_t   got;
  line_word_t   want;

  logic next_ready = 1'b0;
  logic in_fire = 1'b0;
  logic burst_mode = 1'b1;
  logic hold_arm = 1'b0;
  logic rx_hold = 1'b0;
  int lead_gap = 0;
  int out_gap = 0;
  int calm_left = 0;
  int pushed_count = 0;
  int taken_count = 0;
  int out_count = 0;
  int streamed_chars = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int random_start;
  int kind;

  // predictor state
  logic [CHAR_W-1:0] build_buf [CAP];
  logic [POS_W-1:0]  build_len = '0;
  logic              ovf_flag = 1'b0;
  logic [CHAR_W-1:0] ring_buf [QUEUE_LINES][CAP];
  logic [POS_W-1:0]  ring_len [QUEUE_LINES];
  logic [SLOT_W-1:0] wr_slot = '0;
  logic [SLOT_W-1:0] rd_slot = '0;
  logic [CNT_W-1:0]  ring_count = '0;
  logic [STAT_W-1:0] n_recv = '0;
  logic [STAT_W-1:0] n_drop = '0;
  logic [STAT_W-1:0] n_ovf = '0;
  logic [STAT_W-1:0] n_err = '0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [STAT_W-1:0] got_v,
                                 input logic [STAT_W-1:0] want_v);
    fail_count++;
    if (fail_count <= PRINT_LIMIT)
      $display("mismatch at output word %0d: %s got %0h expected %0h",
               out_count, what, got_v, want_v);
  endtask

  task automatic check_field(input string what, input logic [STAT_W-1:0] got_v,
                             input logic [STAT_W-1:0] want_v);
    if (got_v !== want_v) report_mismatch(what, got_v, want_v);
  endtask

  task automatic push_result(input logic avail, input logic valid,
                             input logic [CHAR_W-1:0] ch, input logic is_last);
    line_word_t w;
    w.res.avail      = avail;
    w.res.valid      = valid;
    w.res.ch         = ch;
    w.res.last       = is_last;
    w.st.queued      = QUEUED_W'(ring_count);
    w.st.received    = n_recv;
    w.st.dropped     = n_drop;
    w.st.overflowed  = n_ovf;
    w.st.errors      = n_err;
    expected_words.push_back(w);
  endtask

  task automatic line_queue_predict(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] rx,
                                    input logic [SIZE_W-1:0] size);
    int n;
    logic [SLOT_W-1:0] slot;
    if (op == lasm_pkg::OP_BYTE) begin
      if (rx == lasm_pkg::CH_NL) begin
        if (!ovf_flag && build_len != 0) begin
          if (ring_count < QUEUE_LINES) begin
            for (int i = 0; i < build_len; i++) ring_buf[wr_slot][i] = build_buf[i];
            ring_len[wr_slot] = build_len;
            wr_slot = (wr_slot == SLOT_W'(QUEUE_LINES - 1)) ? '0 : wr_slot + 1'b1;
            ring_count++;
            n_recv++;
          end else begin
            n_drop++;
          end
        end else if (ovf_flag) begin
          n_ovf++;
        end
        build_len = '0;
        ovf_flag  = 1'b0;
      end else if (rx != lasm_pkg::CH_CR && !ovf_flag) begin
        if (build_len < CAP) begin
          build_buf[build_len] = rx;
          build_len++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      push_result(1'b0, 1'b0, '0, 1'b1);
    end else if (op == lasm_pkg::OP_ERROR) begin
      build_len = '0;
      ovf_flag  = 1'b0;
      n_err++;
      push_result(1'b0, 1'b0, '0, 1'b1);
    end else if (op == lasm_pkg::OP_READ && size != 0 && ring_count != 0) begin
      slot = rd_slot;
      n = 0;
      while (n < ring_len[slot] && ring_buf[slot][n] != lasm_pkg::CH_NUL) n++;
      if (n > int'(size) - 1) n = int'(size) - 1;
      rd_slot = (rd_slot == SLOT_W'(QUEUE_LINES - 1)) ? '0 : rd_slot + 1'b1;
      ring_count--;
      if (n == 0) push_result(1'b1, 1'b0, '0, 1'b1);
      for (int k = 0; k < n; k++) push_result(1'b1, 1'b1, ring_buf[slot][k], k == n - 1);
    end else begin
      push_result(1'b0, 1'b0, '0, 1'b1);
    end
  endtask

  task automatic push_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] rx,
                           input logic [SIZE_W-1:0] size);
    serial_word_t w;
    w.op   = op;
    w.rx   = rx;
    w.size = size;
    w.gap  = burst_mode ? 0 : pick_gap();
    pending_words.push_back(w);
    pushed_count++;
  endtask

  // random content, never a newline inside; ends with a newline or an error
  task automatic push_random_line(input int len, input logic end_with_error);
    int r;
    logic [CHAR_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) b = lasm_pkg::CH_NUL;
      else if (r == 1) b = lasm_pkg::CH_CR;
      else begin
        b = CHAR_W'($urandom_range(0, 255));
        if (b == lasm_pkg::CH_NL) b = 8'h20;
      end
      push_word(lasm_pkg::OP_BYTE, b, SIZE_W'($urandom_range(0, 65535)));
    end
    if (end_with_error)
      push_word(lasm_pkg::OP_ERROR, CHAR_W'($urandom_range(0, 255)),
                SIZE_W'($urandom_range(0, 65535)));
    else push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_NL, SIZE_W'($urandom_range(0, 65535)));
  endtask

  task automatic wait_drained();
    while (taken_count != pushed_count || expected_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_line_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 86) return $urandom_range(1, 8);
    if (r < 93) return $urandom_range(58, 63);
    return $urandom_range(64, 70);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_read_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return 16'd1;
    if (r < 28) return 16'hFFFF;
    return SIZE_W'($urandom_range(2, 70));
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (!s_valid || in_fire) begin
      if (!next_ready && pending_words.size() != 0) begin
        next_word  = pending_words.pop_front();
        next_ready = 1'b1;
        lead_gap   = next_word.gap;
      end
      if (next_ready && lead_gap == 0) begin
        s_valid    <= 1'b1;
        s_tdata    <= {next_word.size, next_word.rx};
        s_tuser    <= next_word.op;
        next_ready = 1'b0;
      end else begin
        s_valid <= 1'b0;
        if (next_ready) lead_gap--;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 399) == 0) calm_left = $urandom_range(80, 300);
    if (rx_hold) begin
      m_ready <= 1'b0;
    end else if (out_gap > 0) begin
      m_ready <= 1'b0;
      out_gap--;
    end else begin
      m_ready <= 1'b1;
      if (calm_left == 0 && $urandom_range(0, 3) == 0) out_gap = pick_gap();
    end
  end

  // long receiver hold-off to back the block up into its input
  initial begin
    while (!hold_arm) @(negedge clk_i);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    in_fire = rst_n && s_valid && s_axis_tready_o;
    if (in_fire) begin
      line_queue_predict(s_tuser, s_tdata[7:0], s_tdata[23:8]);
      taken_count++;
    end
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      got.res.avail     = m_axis_tuser_o[0];
      got.res.valid     = m_axis_tuser_o[1];
      got.res.ch        = m_axis_tdata_o[7:0];
      got.res.last      = m_axis_tlast_o;
      got.st.queued     = m_axis_tdata_o[11:8];
      got.st.received   = m_axis_tdata_o[43:12];
      got.st.dropped    = m_axis_tdata_o[75:44];
      got.st.overflowed = m_axis_tdata_o[107:76];
      got.st.errors     = m_axis_tdata_o[139:108];
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, char", got.res.ch, '0);
      end else begin
        want = expected_words.pop_front();
        check_field("line_popped", got.res.avail, want.res.avail);
        check_field("char_valid", got.res.valid, want.res.valid);
        check_field("char_out", got.res.ch, want.res.ch);
        check_field("last", got.res.last, want.res.last);
        check_field("queued_lines", got.st.queued, want.st.queued);
        check_field("lines_taken", got.st.received, want.st.received);
        check_field("lines_lost", got.st.dropped, want.st.dropped);
        check_field("lines_overflowed", got.st.overflowed, want.st.overflowed);
        check_field("hw_errors", got.st.errors, want.st.errors);
      end
      if (got.res.valid) streamed_chars++;
      out_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_words.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_n = 1'b1;

    // directed: empty ring, spare op, zero bytes, cr, truncation, size extremes
    push_word(lasm_pkg::OP_READ, 8'h00, 16'd5);
    push_word(OP_SPARE, 8'hFF, 16'hFFFF);
    push_word(lasm_pkg::OP_ERROR, 8'h00, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, 8'h41, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, 8'hFF, 16'hFFFF);
    push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_CR, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_NUL, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, 8'h42, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_NL, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_NL, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_CR, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_NL, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_NUL, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_NL, 16'h0000);
    push_word(lasm_pkg::OP_READ, 8'h00, 16'd0);
    push_word(lasm_pkg::OP_READ, 8'hFF, 16'hFFFF);
    push_word(lasm_pkg::OP_READ, 8'h00, 16'd1);
    push_word(lasm_pkg::OP_BYTE, 8'h78, 16'h0000);
    push_word(lasm_pkg::OP_ERROR, 8'hFF, 16'hFFFF);
    push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_NL, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, 8'h71, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, 8'h72, 16'h0000);
    push_word(lasm_pkg::OP_BYTE, lasm_pkg::CH_NL, 16'h0000);
    push_word(lasm_pkg::OP_READ, 8'h00, 16'd2);
    wait_drained();

    // fill the ring past full while the receiver holds off
    hold_arm = 1'b1;
    for (int i = 0; i < QUEUE_LINES + 2; i++) push_random_line(3, 1'b0);
    for (int i = 0; i < 4; i++) push_word(lasm_pkg::OP_READ, 8'h00, 16'd8);
    wait_drained();

    random_start = pushed_count;
    while (pushed_count < random_start + RANDOM_WORDS) begin
      if ($urandom_range(0, 7) == 0) burst_mode = !burst_mode;
      kind = $urandom_range(0, 99);
      if (kind < 45) push_random_line(pick_line_len(), $urandom_range(0, 9) == 0);
      else if (kind < 80)
        push_word(lasm_pkg::OP_READ, CHAR_W'($urandom_range(0, 255)), pick_read_size());
      else if (kind < 88)
        push_word(lasm_pkg::OP_ERROR, CHAR_W'($urandom_range(0, 255)),
                  SIZE_W'($urandom_range(0, 65535)));
      else if (kind < 92)
        push_word(OP_SPARE, CHAR_W'($urandom_range(0, 255)),
                  SIZE_W'($urandom_range(0, 65535)));
      else
        push_word(lasm_pkg::OP_BYTE, CHAR_W'($urandom_range(0, 255)),
                  SIZE_W'($urandom_range(0, 65535)));
    end
    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("ran %0d input words and %0d output words, %0d characters read back",
             taken_count, out_count, streamed_chars);
    $display("lines queued %0d, dropped on full ring %0d, overflowed %0d, error events %0d",
             n_recv, n_drop, n_ovf, n_err);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
